// ----- sv/hpsdt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpsdt_pkg
// Types and constants shared by the :status dynamic table coder and its cells.
// ----------------------------------------------------------------------------
package hpsdt_pkg;

	// field widths
	localparam int STATUS_W = 10;
	localparam int SIZE_W   = 31;
	localparam int KIND_W   = 3;
	localparam int INDEX_W  = 7;
	localparam int COUNT_W  = 5;
	localparam int BYTES_W  = 10;

	// entry cost: name (7) + three digits (3) + overhead (32)
	localparam int unsigned ENTRY_COST = 42;

	// index constants
	localparam int unsigned STATIC_STATUS_INDEX = 8;
	localparam int unsigned DYN_INDEX_BASE      = 62;

	// status range and the statically indexed code
	localparam logic [STATUS_W-1:0] STATUS_MIN    = 10'd100;
	localparam logic [STATUS_W-1:0] STATUS_MAX    = 10'd999;
	localparam logic [STATUS_W-1:0] STATUS_STATIC = 10'd200;

	// budget loaded at power-up
	localparam logic [SIZE_W-1:0] BUDGET_RESET = 31'd4096;

	typedef enum logic [1:0] {
		OP_ENCODE      = 2'd0,
		OP_SET_SIZE    = 2'd1,
		OP_RESET_TABLE = 2'd2
	} hpsdt_op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_REJECT   = 3'd0,
		KIND_STATIC   = 3'd1,
		KIND_DYNAMIC  = 3'd2,
		KIND_LITERAL  = 3'd3,
		KIND_SETTINGS = 3'd4
	} hpsdt_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_RES
	} hpsdt_state_t;

	// control broadcast to every cell
	typedef struct packed {
		logic                shift;
		logic [STATUS_W-1:0] key;
	} hpsdt_cell_ctl_t;

	// per-cell registered flags
	typedef struct packed {
		logic hit;
		logic fit;
	} hpsdt_cell_flag_t;

endpackage

// ----- sv/hpsdt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpsdt_cell
// One table slot: holds a stored status, shifts toward the older end on
// insert, and registers its own key match and budget fit flags.
// ----------------------------------------------------------------------------
module hpsdt_cell
	import hpsdt_pkg::*;
#(
	parameter int SLOT   = 0,
	parameter int LIVE_W = 5
) (
	input  logic                    clk,
	input  hpsdt_cell_ctl_t         ctl,
	input  logic [STATUS_W-1:0]     prev_status,
	input  logic [LIVE_W-1:0]       live,
	input  logic [SIZE_W-1:0]       budget,
	output logic [STATUS_W-1:0]     status,
	output hpsdt_cell_flag_t        flag
);

	// bytes needed to keep this slot and all newer ones
	localparam logic [SIZE_W-1:0] NEED = SIZE_W'((SLOT + 1) * ENTRY_COST);

	logic [STATUS_W-1:0] status_q;
	logic                hit_q;
	logic                fit_q;

	// stored status, shifted in from the newer neighbor
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			status_q <= prev_status;
		end
	end

	// match and fit flags, refreshed every cycle
	always_ff @(posedge clk) begin
		hit_q <= (status_q == ctl.key) && (LIVE_W'(SLOT) < live);
		fit_q <= (budget >= NEED);
	end

	assign status   = status_q;
	assign flag.hit = hit_q;
	assign flag.fit = fit_q;

endmodule

// ----- sv/hpack_status_dynamic_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpack_status_dynamic_table
// HPACK :status coding choice with a small dynamic table kept in a row of cells.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result appears on
// the result ports for one cycle with done high. Busy is already low while
// done is high, so the next word may be taken then, but not before the last
// word is through. The steps are set by the sequencer and the cell row: in
// the compare state every slot registers its key match and budget fit flags;
// in the resolve state the first match and the fitting entry count are
// resolved, the table is updated and the result is registered for
// presentation. Results cannot be held off; the receiver must take done when
// it comes. The initial table size register is always ready and is loaded
// into the budget by the reset operation.
module hpack_status_dynamic_table
	import hpsdt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// command channel
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          operation,
	input  logic [STATUS_W-1:0] status_code,
	input  logic [SIZE_W-1:0]   new_table_size,
	// result channel
	output logic                done,
	output logic [KIND_W-1:0]   coding_kind,
	output logic [INDEX_W-1:0]  header_index,
	output logic [STATUS_W-1:0] status_echo,
	output logic                was_inserted,
	output logic [COUNT_W-1:0]  entry_count,
	output logic [BYTES_W-1:0]  table_bytes,
	// configuration channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [SIZE_W-1:0]   cfg_data
);

	localparam int LIVE_W = $clog2(TABLE_ENTRIES + 1);
	localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	hpsdt_state_t        state_q, state_d;
	logic                accept;

	logic [SIZE_W-1:0]   init_size_q;
	logic [SIZE_W-1:0]   budget_q;
	logic [LIVE_W-1:0]   live_q, live_d;

	logic [1:0]          op_s1;
	logic [STATUS_W-1:0] status_s1;

	hpsdt_cell_ctl_t     cell_ctl;
	hpsdt_cell_flag_t    cell_flag [TABLE_ENTRIES];
	logic [STATUS_W-1:0] cell_status [TABLE_ENTRIES];

	logic                hit_any;
	logic [SLOT_W-1:0]   hit_slot;
	logic [LIVE_W-1:0]   live_shrunk;
	logic [LIVE_W-1:0]   live_grown;
	logic                status_ok;

	hpsdt_kind_t         kind_d;
	logic [INDEX_W-1:0]  index_d;
	logic [STATUS_W-1:0] echo_d;
	logic                ins_d;

	logic                done_q;
	hpsdt_kind_t         kind_q;
	logic [INDEX_W-1:0]  index_q;
	logic [STATUS_W-1:0] echo_q;
	logic                ins_q;
	logic [COUNT_W-1:0]  count_q;
	logic [BYTES_W-1:0]  bytes_q;

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = ST_RES;
			end
			ST_RES: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// command word capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= operation;
			status_s1 <= status_code;
		end
	end

	// initial size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_size_q <= BUDGET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			init_size_q <= cfg_data;
		end
	end

	// byte budget, updated as the command is taken so cells see it next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_RESET;
		end else if (accept) begin
			if (operation == OP_SET_SIZE && new_table_size != '0) begin
				budget_q <= new_table_size;
			end else if (operation == OP_RESET_TABLE) begin
				budget_q <= init_size_q;
			end
		end
	end

	// row of slot cells, slot 0 newest
	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		logic [STATUS_W-1:0] prev;
		if (g == 0) begin : g_head
			assign prev = status_s1;
		end else begin : g_link
			assign prev = cell_status[g-1];
		end
		hpsdt_cell #(
			.SLOT   (g),
			.LIVE_W (LIVE_W)
		) u_cell (
			.clk         (clk),
			.ctl         (cell_ctl),
			.prev_status (prev),
			.live        (live_q),
			.budget      (budget_q),
			.status      (cell_status[g]),
			.flag        (cell_flag[g])
		);
	end

	// first matching slot and entry counts that fit the budget
	always_comb begin
		hit_any     = 1'b0;
		hit_slot    = '0;
		live_shrunk = '0;
		live_grown  = '0;
		for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
			if (cell_flag[k].hit) begin
				hit_any  = 1'b1;
				hit_slot = SLOT_W'(k);
			end
		end
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			if (cell_flag[k].fit && LIVE_W'(k) < live_q) begin
				live_shrunk = LIVE_W'(k + 1);
			end
			if (cell_flag[k].fit && LIVE_W'(k) <= live_q) begin
				live_grown = LIVE_W'(k + 1);
			end
		end
	end

	assign status_ok = (status_s1 >= STATUS_MIN) && (status_s1 <= STATUS_MAX);

	// result selection and table update
	always_comb begin
		kind_d         = KIND_REJECT;
		index_d        = '0;
		echo_d         = '0;
		ins_d          = 1'b0;
		live_d         = live_q;
		cell_ctl.key   = status_s1;
		cell_ctl.shift = 1'b0;
		case (op_s1)
			OP_ENCODE: begin
				if (!status_ok) begin
					kind_d = KIND_REJECT;
				end else if (status_s1 == STATUS_STATIC) begin
					kind_d  = KIND_STATIC;
					index_d = INDEX_W'(STATIC_STATUS_INDEX);
				end else if (hit_any) begin
					kind_d  = KIND_DYNAMIC;
					index_d = INDEX_W'(DYN_INDEX_BASE + 32'(hit_slot));
				end else begin
					kind_d  = KIND_LITERAL;
					index_d = INDEX_W'(STATIC_STATUS_INDEX);
					echo_d  = status_s1;
					ins_d   = cell_flag[0].fit;
					live_d  = live_grown;
					cell_ctl.shift = (state_q == ST_RES) && cell_flag[0].fit;
				end
			end
			OP_SET_SIZE: begin
				kind_d = KIND_SETTINGS;
				live_d = live_shrunk;
			end
			OP_RESET_TABLE: begin
				kind_d = KIND_SETTINGS;
				live_d = '0;
			end
			default: begin
				kind_d = KIND_REJECT;
			end
		endcase
	end

	// live entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
		end else if (state_q == ST_RES) begin
			live_q <= live_d;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_RES);
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (state_q == ST_RES) begin
			kind_q  <= kind_d;
			index_q <= index_d;
			echo_q  <= echo_d;
			ins_q   <= ins_d;
			count_q <= COUNT_W'(live_d);
			bytes_q <= BYTES_W'(32'(live_d) * ENTRY_COST);
		end
	end

	assign done         = done_q;
	assign coding_kind  = kind_q;
	assign header_index = index_q;
	assign status_echo  = echo_q;
	assign was_inserted = ins_q;
	assign entry_count  = count_q;
	assign table_bytes  = bytes_q;

	// checks
	a_done_follows_res: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_RES))
		else $error("result strobe without a resolve cycle");

	a_live_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= LIVE_W'(TABLE_ENTRIES))
		else $error("live entry count above table depth");

	a_insert_is_literal: assert property (@(posedge clk) disable iff (!arst_n)
		done && was_inserted |-> coding_kind == KIND_LITERAL && live_q != '0)
		else $error("insert reported without a stored literal");

	a_insert_at_head: assert property (@(posedge clk) disable iff (!arst_n)
		done && was_inserted |-> cell_status[0] == status_echo)
		else $error("inserted status not at the newest slot");

endmodule
